[rtl/mfde_pkg.sv]
// Shared types and codes for the monochrome frame store draw engine.
// No dependencies; imported by the front end, the back end and the top unit.
`default_nettype none

package mfde_pkg;

	localparam int CMD_W   = 4;
	localparam int COORD_W = 9;
	localparam int BADDR_W = 10;
	localparam int DATA_W  = 8;
	localparam int CRD_W   = 8;

	localparam logic [CMD_W-1:0] CMD_SET     = 4'd0;
	localparam logic [CMD_W-1:0] CMD_CLR     = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INV     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_FILL    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_OUTLINE = 4'd4;
	localparam logic [CMD_W-1:0] CMD_CLRALL  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_WRITE   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_READ    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_SHUP    = 4'd8;
	localparam logic [CMD_W-1:0] CMD_SHDN    = 4'd9;

	localparam logic [2:0] JOB_NONE   = 3'd0;
	localparam logic [2:0] JOB_RECT   = 3'd1;
	localparam logic [2:0] JOB_CLRALL = 3'd2;
	localparam logic [2:0] JOB_WRITE  = 3'd3;
	localparam logic [2:0] JOB_READ   = 3'd4;
	localparam logic [2:0] JOB_SHUP   = 3'd5;
	localparam logic [2:0] JOB_SHDN   = 3'd6;

	localparam logic [1:0] MODE_CLR = 2'd0;
	localparam logic [1:0] MODE_SET = 2'd1;
	localparam logic [1:0] MODE_TOG = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         mode;
		logic               last;
		logic               rej;
		logic [CRD_W-1:0]   xs;
		logic [CRD_W-1:0]   xe;
		logic [CRD_W-1:0]   ys;
		logic [CRD_W-1:0]   ye;
		logic [BADDR_W-1:0] addr;
		logic [DATA_W-1:0]  data;
	} job_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              rejected;
	} res_t;

endpackage

`default_nettype wire

[rtl/mfde_fifo.sv]
// Two-entry register queue used between front and back and on the result side.
// Depends on nothing but its WIDTH parameter.
`default_nettype none

module mfde_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] buf_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = buf_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) buf_q[wp_q] <= wdata;
	end

endmodule

`default_nettype wire

[rtl/mfde_front.sv]
// Front end: takes commands, classifies them and splits them into clipped jobs.
// Uses mfde_pkg for command codes and the job record.
`default_nettype none

module mfde_front
	import mfde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      init_busy,
	input  wire logic                      push,
	input  wire logic [CMD_W-1:0]          command,
	input  wire logic signed [COORD_W-1:0] x_start,
	input  wire logic signed [COORD_W-1:0] y_start,
	input  wire logic signed [COORD_W-1:0] x_end,
	input  wire logic signed [COORD_W-1:0] y_end,
	input  wire logic                      fill_value,
	input  wire logic [BADDR_W-1:0]        byte_address,
	input  wire logic [DATA_W-1:0]         byte_data,
	output logic                           full,
	output logic                           job_push,
	output job_t                           job,
	input  wire logic                      job_full
);

	localparam logic signed [10:0] XMAX = 11'(SCREEN_WIDTH - 1);
	localparam logic signed [10:0] YMAX = 11'(SCREEN_HEIGHT - 1);

	logic                      hold_q;
	logic [1:0]                jcnt_q;
	logic [CMD_W-1:0]          cmd_q;
	logic signed [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic                      fill_q;
	logic [BADDR_W-1:0]        addr_q;
	logic [DATA_W-1:0]         data_q;

	logic signed [10:0] sx1, sy1, sx2, sy2;
	logic signed [10:0] ax0, ax1, ay0, ay1;
	logic signed [10:0] cx0, cx1, cy0, cy1;
	logic [2:0]         op_c;
	logic [1:0]         mode_c;
	logic               rej_c, last_c, emit_last, accept;

	assign sx1 = {{2{x1_q[COORD_W-1]}}, x1_q};
	assign sy1 = {{2{y1_q[COORD_W-1]}}, y1_q};
	assign sx2 = {{2{x2_q[COORD_W-1]}}, x2_q};
	assign sy2 = {{2{y2_q[COORD_W-1]}}, y2_q};

	always_comb begin
		ax0    = sx1;
		ax1    = sx2;
		ay0    = sy1;
		ay1    = sy2;
		op_c   = JOB_RECT;
		mode_c = MODE_SET;
		rej_c  = 1'b0;
		last_c = 1'b1;
		case (cmd_q)
			CMD_SET: begin
				ax1 = sx1;
				ay1 = sy1;
			end
			CMD_CLR: begin
				ax1    = sx1;
				ay1    = sy1;
				mode_c = MODE_CLR;
			end
			CMD_INV: begin
				mode_c = MODE_TOG;
				rej_c  = (sx1 < 0) || (sy1 < 0) || (sx2 < 0) || (sy2 < 0) ||
					(sx1 > XMAX) || (sy1 > YMAX) || (sx2 > XMAX) || (sy2 > YMAX);
				if (rej_c) op_c = JOB_NONE;
			end
			CMD_FILL: mode_c = fill_q ? MODE_SET : MODE_CLR;
			CMD_OUTLINE: begin
				last_c = (jcnt_q == 2'd3);
				case (jcnt_q)
					2'd0: ay1 = sy1;
					2'd1: ay0 = sy2;
					2'd2: begin
						ax1 = sx1;
						ay0 = sy1 + 11'sd1;
						ay1 = sy2 - 11'sd1;
					end
					default: begin
						ax0 = sx2;
						ay0 = sy1 + 11'sd1;
						ay1 = sy2 - 11'sd1;
					end
				endcase
			end
			CMD_CLRALL: op_c = JOB_CLRALL;
			CMD_WRITE:  op_c = JOB_WRITE;
			CMD_READ:   op_c = JOB_READ;
			CMD_SHUP:   op_c = JOB_SHUP;
			CMD_SHDN:   op_c = JOB_SHDN;
			default:    op_c = JOB_NONE;
		endcase
		// clip to the screen; an empty rectangle does nothing
		cx0 = (ax0 < 0) ? 11'sd0 : ax0;
		cx1 = (ax1 > XMAX) ? XMAX : ax1;
		cy0 = (ay0 < 0) ? 11'sd0 : ay0;
		cy1 = (ay1 > YMAX) ? YMAX : ay1;
		if (op_c == JOB_RECT && ((cx0 > cx1) || (cy0 > cy1))) op_c = JOB_NONE;
	end

	always_comb begin
		job.op   = op_c;
		job.mode = mode_c;
		job.last = last_c;
		job.rej  = rej_c;
		job.xs   = cx0[CRD_W-1:0];
		job.xe   = cx1[CRD_W-1:0];
		job.ys   = cy0[CRD_W-1:0];
		job.ye   = cy1[CRD_W-1:0];
		job.addr = addr_q;
		job.data = data_q;
	end

	assign job_push  = hold_q;
	assign emit_last = hold_q && last_c && !job_full;
	assign full      = init_busy || (hold_q && !emit_last);
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			jcnt_q <= 2'd0;
		end else if (accept) begin
			hold_q <= 1'b1;
			jcnt_q <= 2'd0;
		end else if (hold_q && !job_full) begin
			if (last_c) hold_q <= 1'b0;
			else jcnt_q <= jcnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			x1_q   <= x_start;
			y1_q   <= y_start;
			x2_q   <= x_end;
			y2_q   <= y_end;
			fill_q <= fill_value;
			addr_q <= byte_address;
			data_q <= byte_data;
		end
	end

endmodule

`default_nettype wire

[rtl/mfde_back.sv]
// Back end: owns the frame store; does byte reads and writes, clears, row shifts and read-modify-write pixel sweeps.
// Uses mfde_pkg for the job and result records.
`default_nettype none

module mfde_back
	import mfde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int STORE_BYTES   = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic debug,
	input  wire logic job_empty,
	input  job_t      job_in,
	output logic      job_pop,
	output logic      res_push,
	output res_t      res,
	input  wire logic res_full,
	output logic      init_busy
);

	localparam int AW   = $clog2(STORE_BYTES);
	localparam int ROWS = SCREEN_HEIGHT / 8;
	localparam int RW   = $clog2(ROWS + 1);
	localparam logic signed [15:0] STORE_S = 16'(STORE_BYTES);
	localparam logic signed [15:0] W_S     = 16'(SCREEN_WIDTH);
	localparam logic [15:0]        STORE_U = 16'(STORE_BYTES);
	localparam logic [15:0]        W_U     = 16'(SCREEN_WIDTH);
	localparam logic [CRD_W-1:0]   IMAX    = CRD_W'(SCREEN_WIDTH - 1);
	localparam logic [CRD_W-1:0]   IDNMAX  = CRD_W'(SCREEN_WIDTH - 5);
	localparam logic [RW-1:0]      JMAX    = RW'(ROWS - 1);
	localparam logic [AW-1:0]      CA_LAST = AW'(STORE_BYTES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_RRD  = 3'd2;
	localparam logic [2:0] ST_RWR  = 3'd3;
	localparam logic [2:0] ST_SRD  = 3'd4;
	localparam logic [2:0] ST_SWR  = 3'd5;
	localparam logic [2:0] ST_RD2  = 3'd6;
	localparam logic [2:0] ST_RESP = 3'd7;

	logic [DATA_W-1:0] mem [STORE_BYTES];
	logic [DATA_W-1:0] rdata_q;

	logic [2:0]       state_q;
	logic             init_q;
	job_t             job_q;
	logic [CRD_W-1:0] cx_q, cy_q, si_q;
	logic [RW-1:0]    sj_q;
	logic [15:0]      base_q;
	logic [AW-1:0]    ca_q, pa_q, sdst_q;
	logic             pok_q, sdok_q, szero_q;
	logic [7:0]       pmask_q;
	res_t             res_q;

	logic [AW-1:0]     ra_c, wa_c;
	logic              we_c;
	logic [DATA_W-1:0] wd_c, rmw_c, ovl_c, rd_c;
	logic signed [15:0] pmul, pix_a, ox, od;
	logic [15:0]       sh_dst, sh_src, addr_u;
	logic              up, src_ok, last_i, fin_c, last_c, addr_ok;
	res_t              res_c;

	assign init_busy = init_q;
	assign up        = (job_q.op == JOB_SHUP);
	assign pmul      = $signed({11'b0, cy_q[7:3]}) * W_S;
	assign pix_a     = STORE_S - 16'sd1 - $signed({8'b0, cx_q}) - pmul;
	assign sh_dst    = base_q + {8'b0, si_q};
	assign sh_src    = up ? (sh_dst - 16'd4) : (sh_dst + 16'd4);
	assign src_ok    = (up ? (si_q >= 8'd4) : (si_q <= IDNMAX)) && (sh_src < STORE_U);
	assign last_i    = up ? (si_q == '0) : (si_q == IMAX);
	assign addr_u    = {6'b0, job_q.addr};
	assign addr_ok   = addr_u < STORE_U;

	// corner triangle toggle: column x of page 0 holds rows 0..x-(W-5)
	always_comb begin
		ox    = STORE_S - 16'sd1 - $signed(addr_u);
		od    = ox - W_S + 16'sd5;
		ovl_c = '0;
		for (int r = 0; r < 5; r++) begin
			if (debug && od >= 16'(r) && od <= 16'sd4) ovl_c[7-r] = 1'b1;
		end
		rd_c = (addr_ok ? rdata_q : 8'd0) ^ ovl_c;
	end

	always_comb begin
		case (job_q.mode)
			MODE_SET: rmw_c = rdata_q | pmask_q;
			MODE_CLR: rmw_c = rdata_q & ~pmask_q;
			default:  rmw_c = rdata_q ^ pmask_q;
		endcase
	end

	always_comb begin
		ra_c    = '0;
		wa_c    = '0;
		we_c    = 1'b0;
		wd_c    = '0;
		job_pop = 1'b0;
		fin_c   = 1'b0;
		last_c  = job_q.last;
		res_c   = '0;
		case (state_q)
			ST_IDLE: begin
				last_c = job_in.last;
				res_c.rejected = job_in.rej;
				if (!job_empty) begin
					job_pop = 1'b1;
					ra_c    = AW'(job_in.addr);
					wa_c    = AW'(job_in.addr);
					wd_c    = job_in.data;
					we_c    = (job_in.op == JOB_WRITE) && ({6'b0, job_in.addr} < STORE_U);
					fin_c   = (job_in.op == JOB_NONE) || (job_in.op == JOB_WRITE);
				end
			end
			ST_CLR: begin
				we_c  = 1'b1;
				wa_c  = ca_q;
				fin_c = (ca_q == CA_LAST) && !init_q;
			end
			ST_RRD: ra_c = pix_a[AW-1:0];
			ST_RWR: begin
				we_c  = pok_q;
				wa_c  = pa_q;
				wd_c  = rmw_c;
				fin_c = (cx_q == job_q.xe) && (cy_q == job_q.ye);
			end
			ST_SRD: ra_c = sh_src[AW-1:0];
			ST_SWR: begin
				we_c  = sdok_q;
				wa_c  = sdst_q;
				wd_c  = szero_q ? 8'd0 : rdata_q;
				fin_c = last_i && (sj_q == JMAX);
			end
			ST_RD2: begin
				res_c.read_data = rd_c;
				fin_c = 1'b1;
			end
			ST_RESP: res_c = res_q;
			default: ;
		endcase
	end

	assign res_push = ((fin_c && last_c) || (state_q == ST_RESP)) && !res_full;
	assign res      = res_c;

	always_ff @(posedge clk) begin
		if (we_c) mem[wa_c] <= wd_c;
		rdata_q <= mem[ra_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q  <= 1'b1;
			ca_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						case (job_in.op)
							JOB_RECT:   state_q <= ST_RRD;
							JOB_CLRALL: state_q <= ST_CLR;
							JOB_READ:   state_q <= ST_RD2;
							JOB_SHUP:   state_q <= ST_SRD;
							JOB_SHDN:   state_q <= ST_SRD;
							default:    state_q <= ST_IDLE;
						endcase
						ca_q <= '0;
					end
				end
				ST_CLR: begin
					ca_q <= ca_q + AW'(1);
					if (ca_q == CA_LAST) begin
						init_q <= 1'b0;
						if (init_q) state_q <= ST_IDLE;
					end
				end
				ST_RRD:  state_q <= ST_RWR;
				ST_RWR:  if (!fin_c) state_q <= ST_RRD;
				ST_SRD:  state_q <= ST_SWR;
				ST_SWR:  if (!fin_c) state_q <= ST_SRD;
				ST_RESP: if (!res_full) state_q <= ST_IDLE;
				default: ;
			endcase
			if (fin_c) state_q <= (last_c && res_full) ? ST_RESP : ST_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_c) res_q <= res_c;
		case (state_q)
			ST_IDLE: begin
				job_q <= job_in;
				cx_q  <= job_in.xs;
				cy_q  <= job_in.ys;
				si_q  <= (job_in.op == JOB_SHUP) ? IMAX : '0;
				sj_q  <= '0;
				base_q <= '0;
			end
			ST_RRD: begin
				pa_q    <= pix_a[AW-1:0];
				pok_q   <= !pix_a[15];
				pmask_q <= 8'h80 >> cy_q[2:0];
			end
			ST_RWR: begin
				if (cy_q == job_q.ye) begin
					cy_q <= job_q.ys;
					cx_q <= cx_q + 8'd1;
				end else begin
					cy_q <= cy_q + 8'd1;
				end
			end
			ST_SRD: begin
				sdst_q  <= sh_dst[AW-1:0];
				sdok_q  <= sh_dst < STORE_U;
				szero_q <= !src_ok;
			end
			ST_SWR: begin
				if (last_i) begin
					sj_q   <= sj_q + RW'(1);
					base_q <= base_q + W_U;
					si_q   <= up ? IMAX : '0;
				end else begin
					si_q <= up ? (si_q - 8'd1) : (si_q + 8'd1);
				end
			end
			default: ;
		endcase
	end

	a_no_job_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !job_pop)
		else $error("job taken during the clearing pass");

	a_res_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_init_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(init_q) |-> (state_q == ST_IDLE))
		else $error("clearing pass did not end in idle");

endmodule

`default_nettype wire

[rtl/mono_framebuffer_draw_engine_unit.sv]
// Byte writes are taken one per cycle while the job and result queues have room;
// pixels and rectangles walk a read state and a write state (ST_RRD, ST_RWR) per
// clipped pixel, shifts walk ST_SRD and ST_SWR per byte of SCREEN_HEIGHT/8 rows,
// and a clear writes every byte of the store. The back end takes no new job until
// the current one is done; the two-entry job queue holds later commands meanwhile.
// Reset: queues empty, debug_overlay 0, then a clearing pass zeroes every byte of
// the store while full stays high.
`default_nettype none

module mono_framebuffer_draw_engine_unit
	import mfde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int STORE_BYTES   = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic                      cfg_data,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [CMD_W-1:0]          command,
	input  wire logic signed [COORD_W-1:0] x_start,
	input  wire logic signed [COORD_W-1:0] y_start,
	input  wire logic signed [COORD_W-1:0] x_end,
	input  wire logic signed [COORD_W-1:0] y_end,
	input  wire logic                      fill_value,
	input  wire logic [BADDR_W-1:0]        byte_address,
	input  wire logic [DATA_W-1:0]         byte_data,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [DATA_W-1:0]              read_data,
	output logic                           rejected
);

	logic debug_overlay_q;
	logic init_busy, job_push, job_full, job_empty, job_pop, res_push, res_full;
	job_t job_w, job_r;
	res_t res_w, res_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) debug_overlay_q <= 1'b0;
		else if (cfg_write) debug_overlay_q <= cfg_data;
	end

	mfde_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.init_busy    (init_busy),
		.push         (push),
		.command      (command),
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.fill_value   (fill_value),
		.byte_address (byte_address),
		.byte_data    (byte_data),
		.full         (full),
		.job_push     (job_push),
		.job          (job_w),
		.job_full     (job_full)
	);

	mfde_fifo #(.WIDTH($bits(job_t))) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_w),
		.full   (job_full),
		.rd     (job_pop),
		.rdata  (job_r),
		.empty  (job_empty)
	);

	mfde_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.STORE_BYTES   (STORE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.debug     (debug_overlay_q),
		.job_empty (job_empty),
		.job_in    (job_r),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res       (res_w),
		.res_full  (res_full),
		.init_busy (init_busy)
	);

	mfde_fifo #(.WIDTH($bits(res_t))) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_w),
		.full   (res_full),
		.rd     (pop),
		.rdata  (res_r),
		.empty  (empty)
	);

	assign read_data = res_r.read_data;
	assign rejected  = res_r.rejected;

endmodule

`default_nettype wire
